### sv/ille_pkg.sv
// shared constants, codes and control types for the indexed linked list engine
`default_nettype none

package ille_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);

    localparam int ACT_W  = 3;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 11;

    localparam logic [ACT_W-1:0] ACT_GET       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_HEAD  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD_TAIL  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ADD_INDEX = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_GET,
        OP_ADD,
        OP_DEL
    } ille_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_WALK_ISSUE,
        S_WALK,
        S_GET_RD,
        S_GET_OUT,
        S_INS_FREE,
        S_INS_HEAD,
        S_INS_PREV,
        S_INS_LINKN,
        S_INS_LINKP,
        S_DEL_RD,
        S_DEL_HEAD,
        S_DEL_VICT,
        S_DEL_LINKP,
        S_DEL_FREE,
        S_FINISH
    } ille_state_t;

    // link memory read address source
    typedef enum logic [1:0] {
        RA_PTR,
        RA_LINK,
        RA_FREE
    } ille_raddr_sel_t;

    // link memory write: address and data sources
    typedef enum logic [2:0] {
        LW_NONE,
        LW_NEW_HEAD,
        LW_NEW_LINK,
        LW_PTR_FREE,
        LW_PTR_LINK,
        LW_AUX_FREE
    } ille_lwr_sel_t;

    typedef enum logic [1:0] {
        HD_KEEP,
        HD_FREE,
        HD_LINK
    } ille_head_sel_t;

    typedef enum logic [1:0] {
        FR_KEEP,
        FR_LINK,
        FR_AUX
    } ille_free_sel_t;

    typedef enum logic [1:0] {
        AX_KEEP,
        AX_LINK,
        AX_PTR
    } ille_aux_sel_t;

    typedef enum logic [1:0] {
        CN_KEEP,
        CN_INC,
        CN_DEC
    } ille_cnt_sel_t;

    typedef struct packed {
        logic            capture;
        logic            walk_load;
        logic            step_dec;
        logic            ptr_from_link;
        ille_raddr_sel_t raddr_sel;
        ille_lwr_sel_t   lwr_sel;
        logic            val_write;
        ille_head_sel_t  head_sel;
        ille_free_sel_t  free_sel;
        ille_aux_sel_t   aux_sel;
        ille_cnt_sel_t   cnt_sel;
        logic            res_init;
        logic            res_value_load;
        logic            out_load;
    } ille_cmd_t;

    typedef struct packed {
        ille_op_t op;
        logic     fail;
        logic     k_zero;
        logic     target_zero;
        logic     steps_zero;
        logic     out_free;
    } ille_stat_t;

endpackage

`default_nettype wire

### sv/ille_req_if.sv
// request channel: action, position and value with valid/ready
`default_nettype none

interface ille_req_if import ille_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output action, output position, output item_value,
                    input ready);
    modport sink (input valid, input action, input position, input item_value,
                  output ready);
endinterface

`default_nettype wire

### sv/ille_rsp_if.sv
// response channel: read value, status and length with valid/ready
`default_nettype none

interface ille_rsp_if import ille_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
    logic [LEN_W-1:0]        length;

    modport source (output valid, output read_value, output status, output length,
                    input ready);
    modport sink (input valid, input read_value, input status, input length,
                  output ready);
endinterface

`default_nettype wire

### sv/indexed_linked_list_engine.sv
// top level of the indexed linked list engine
`default_nettype none

// Keeps one singly linked list of signed 32-bit values in a pool of CAPACITY nodes, with
// unused nodes chained on a free list. Each request item gives exactly one response item
// carrying the value read by a get (-1 otherwise), a status (done, out of range, pool full)
// and the list length after the request. One request is in flight at a time; a new request
// is taken while the previous response still waits in the output register. A request's
// time grows with the number of links followed, plus any time spent waiting for the
// output register to empty; the walk rate is set by the single read port of the link
// memory, one registered read per cycle. No clearing pass is needed after reset: nodes
// at or above a fill mark read as the initial free chain, so requests are taken
// immediately.
module indexed_linked_list_engine import ille_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    ille_req_if.sink req,
    ille_rsp_if.source rsp
);

    ille_cmd_t  cmd;
    ille_stat_t stat;

    ille_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ille_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_action     (req.action),
        .req_position   (req.position),
        .req_item_value (req.item_value),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_read_value (rsp.read_value),
        .rsp_status     (rsp.status),
        .rsp_length     (rsp.length)
    );

endmodule

`default_nettype wire

### sv/ille_ctrl.sv
// controller state machine sequencing checks, link walks and list updates
`default_nettype none

module ille_ctrl import ille_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire ille_stat_t stat,
    output ille_cmd_t       cmd
);

    ille_state_t state_reg;
    ille_state_t state_next;
    ille_state_t dispatch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // first state of the update once the walk has reached its node
    always_comb
    begin
        unique case (stat.op)
            OP_GET:  dispatch = S_GET_RD;
            OP_ADD:  dispatch = S_INS_FREE;
            OP_DEL:  dispatch = S_DEL_RD;
            OP_NONE: dispatch = S_FINISH;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.res_init  = 1'b1;
                cmd.walk_load = 1'b1;
                if (stat.op == OP_NONE || stat.fail)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.target_zero)
                begin
                    state_next = dispatch;
                end
                else
                begin
                    state_next = S_WALK_ISSUE;
                end
            end
            S_WALK_ISSUE:
            begin
                cmd.raddr_sel = RA_PTR;
                cmd.step_dec  = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                cmd.ptr_from_link = 1'b1;
                if (stat.steps_zero)
                begin
                    state_next = dispatch;
                end
                else
                begin
                    cmd.raddr_sel = RA_LINK;
                    cmd.step_dec  = 1'b1;
                end
            end
            S_GET_RD:
            begin
                state_next = S_GET_OUT;
            end
            S_GET_OUT:
            begin
                cmd.res_value_load = 1'b1;
                state_next         = S_FINISH;
            end
            S_INS_FREE:
            begin
                cmd.raddr_sel = RA_FREE;
                cmd.val_write = 1'b1;
                state_next    = stat.k_zero ? S_INS_HEAD : S_INS_PREV;
            end
            S_INS_HEAD:
            begin
                cmd.lwr_sel  = LW_NEW_HEAD;
                cmd.head_sel = HD_FREE;
                cmd.free_sel = FR_LINK;
                cmd.cnt_sel  = CN_INC;
                state_next   = S_FINISH;
            end
            S_INS_PREV:
            begin
                cmd.aux_sel   = AX_LINK;
                cmd.raddr_sel = RA_PTR;
                state_next    = S_INS_LINKN;
            end
            S_INS_LINKN:
            begin
                cmd.lwr_sel = LW_NEW_LINK;
                state_next  = S_INS_LINKP;
            end
            S_INS_LINKP:
            begin
                cmd.lwr_sel  = LW_PTR_FREE;
                cmd.free_sel = FR_AUX;
                cmd.cnt_sel  = CN_INC;
                state_next   = S_FINISH;
            end
            S_DEL_RD:
            begin
                cmd.raddr_sel = RA_PTR;
                state_next    = stat.k_zero ? S_DEL_HEAD : S_DEL_VICT;
            end
            S_DEL_HEAD:
            begin
                cmd.head_sel = HD_LINK;
                cmd.aux_sel  = AX_PTR;
                state_next   = S_DEL_FREE;
            end
            S_DEL_VICT:
            begin
                cmd.aux_sel   = AX_LINK;
                cmd.raddr_sel = RA_LINK;
                state_next    = S_DEL_LINKP;
            end
            S_DEL_LINKP:
            begin
                cmd.lwr_sel = LW_PTR_LINK;
                state_next  = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                cmd.lwr_sel  = LW_AUX_FREE;
                cmd.free_sel = FR_AUX;
                cmd.cnt_sel  = CN_DEC;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/ille_datapath.sv
// node memories, list pointers, link walk registers and the result register
`default_nettype none

module ille_datapath import ille_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [ACT_W-1:0]        req_action,
    input  wire logic [POS_W-1:0]        req_position,
    input  wire logic signed [VAL_W-1:0] req_item_value,
    input  wire ille_cmd_t               cmd,
    output ille_stat_t                   stat,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    output logic signed [VAL_W-1:0]      rsp_read_value,
    output logic [STAT_W-1:0]            rsp_status,
    output logic [LEN_W-1:0]             rsp_length
);

    // held request
    logic [ACT_W-1:0]        act_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;

    // list state
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] free_reg;
    logic [LINK_W-1:0] free_next;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic [LINK_W-1:0] wm_reg;
    logic [LINK_W-1:0] wm_next;

    // walk and scratch
    logic [LINK_W-1:0] ptr_reg;
    logic [LINK_W-1:0] aux_reg;
    logic [LEN_W-1:0]  steps_reg;

    // memories
    logic [LINK_W-1:0] link_mem [CAPACITY];
    logic [VAL_W-1:0]  val_mem [CAPACITY];
    logic [LINK_W-1:0] link_q_reg;
    logic              fresh_reg;
    logic [LINK_W-1:0] fresh_val_reg;
    logic [VAL_W-1:0]  val_q_reg;

    // pending result and output register
    logic [STAT_W-1:0]       res_status_reg;
    logic signed [VAL_W-1:0] res_value_reg;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [STAT_W-1:0]       out_status_reg;
    logic [LEN_W-1:0]        out_length_reg;

    ille_op_t          op;
    logic [LEN_W-1:0]  k;
    logic [LEN_W-1:0]  walk_target;
    logic              range_err;
    logic              full_err;
    logic [STAT_W-1:0] chk_status;
    logic [LINK_W-1:0] link_rd;
    logic [LINK_W-1:0] link_raddr;
    logic              lw_en;
    logic [LINK_W-1:0] lw_addr;
    logic [LINK_W-1:0] lw_data;

    // request decode and checks
    always_comb
    begin
        unique case (act_reg)
            ACT_GET:
            begin
                op = OP_GET;
                k  = LEN_W'(pos_reg);
            end
            ACT_ADD_HEAD:
            begin
                op = OP_ADD;
                k  = '0;
            end
            ACT_ADD_TAIL:
            begin
                op = OP_ADD;
                k  = count_reg;
            end
            ACT_ADD_INDEX:
            begin
                op = OP_ADD;
                k  = LEN_W'(pos_reg);
            end
            ACT_DELETE:
            begin
                op = OP_DEL;
                k  = LEN_W'(pos_reg);
            end
            default:
            begin
                op = OP_NONE;
                k  = LEN_W'(pos_reg);
            end
        endcase
    end

    always_comb
    begin
        unique case (op)
            OP_GET:  range_err = (k >= count_reg);
            OP_DEL:  range_err = (k >= count_reg);
            OP_ADD:  range_err = (k > count_reg);
            OP_NONE: range_err = 1'b0;
        endcase
        full_err = (op == OP_ADD) && (count_reg == LEN_W'(CAPACITY));
        priority if (range_err)
        begin
            chk_status = ST_RANGE;
        end
        else if (full_err)
        begin
            chk_status = ST_FULL;
        end
        else
        begin
            chk_status = ST_DONE;
        end
        // get and position zero walk to the node itself, the others to its predecessor
        if (op == OP_GET || k == '0)
        begin
            walk_target = k;
        end
        else
        begin
            walk_target = k - LEN_W'(1);
        end
    end

    assign stat.op          = op;
    assign stat.fail        = range_err || full_err;
    assign stat.k_zero      = (k == '0);
    assign stat.target_zero = (walk_target == '0);
    assign stat.steps_zero  = (steps_reg == '0);
    assign stat.out_free    = !out_valid_reg || rsp_ready;

    // entries at or above the fill mark still hold the initial free chain
    assign link_rd = fresh_reg ? fresh_val_reg : link_q_reg;

    always_comb
    begin
        unique case (cmd.raddr_sel)
            RA_PTR:  link_raddr = ptr_reg;
            RA_LINK: link_raddr = link_rd;
            RA_FREE: link_raddr = free_reg;
            default: link_raddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        lw_en   = 1'b1;
        lw_addr = free_reg;
        lw_data = head_reg;
        unique case (cmd.lwr_sel)
            LW_NONE:
            begin
                lw_en = 1'b0;
            end
            LW_NEW_HEAD:
            begin
                lw_addr = free_reg;
                lw_data = head_reg;
            end
            LW_NEW_LINK:
            begin
                lw_addr = free_reg;
                lw_data = link_rd;
            end
            LW_PTR_FREE:
            begin
                lw_addr = ptr_reg;
                lw_data = free_reg;
            end
            LW_PTR_LINK:
            begin
                lw_addr = ptr_reg;
                lw_data = link_rd;
            end
            LW_AUX_FREE:
            begin
                lw_addr = aux_reg;
                lw_data = free_reg;
            end
            default:
            begin
                lw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr[IDX_W-1:0]] <= lw_data;
        end
        link_q_reg    <= link_mem[link_raddr[IDX_W-1:0]];
        fresh_reg     <= (link_raddr >= wm_reg);
        fresh_val_reg <= link_raddr + LINK_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.val_write)
        begin
            val_mem[free_reg[IDX_W-1:0]] <= val_reg;
        end
        val_q_reg <= val_mem[ptr_reg[IDX_W-1:0]];
    end

    // list state next values
    always_comb
    begin
        head_next  = head_reg;
        free_next  = free_reg;
        count_next = count_reg;
        wm_next    = wm_reg;
        unique case (cmd.head_sel)
            HD_FREE: head_next = free_reg;
            HD_LINK: head_next = link_rd;
            default: head_next = head_reg;
        endcase
        unique case (cmd.free_sel)
            FR_LINK: free_next = link_rd;
            FR_AUX:  free_next = aux_reg;
            default: free_next = free_reg;
        endcase
        unique case (cmd.cnt_sel)
            CN_INC:  count_next = count_reg + LEN_W'(1);
            CN_DEC:  count_next = count_reg - LEN_W'(1);
            default: count_next = count_reg;
        endcase
        if (lw_en && lw_addr == wm_reg)
        begin
            wm_next = wm_reg + LINK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= LINK_W'(CAPACITY);
            free_reg      <= '0;
            count_reg     <= '0;
            wm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            wm_reg    <= wm_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= req_action;
            pos_reg <= req_position;
            val_reg <= req_item_value;
        end
        if (cmd.walk_load)
        begin
            ptr_reg   <= head_reg;
            steps_reg <= walk_target;
        end
        else
        begin
            if (cmd.ptr_from_link)
            begin
                ptr_reg <= link_rd;
            end
            if (cmd.step_dec)
            begin
                steps_reg <= steps_reg - LEN_W'(1);
            end
        end
        unique case (cmd.aux_sel)
            AX_LINK: aux_reg <= link_rd;
            AX_PTR:  aux_reg <= ptr_reg;
            default: aux_reg <= aux_reg;
        endcase
        if (cmd.res_init)
        begin
            res_status_reg <= chk_status;
            res_value_reg  <= '1;
        end
        else if (cmd.res_value_load)
        begin
            res_value_reg <= val_q_reg;
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_length_reg <= count_reg;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_read_value = out_value_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_length     = out_length_reg;

`ifndef SYNTH
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && !$stable(count_reg) |->
            (count_reg == $past(count_reg) + LEN_W'(1)) ||
            (count_reg == $past(count_reg) - LEN_W'(1)))
        else $error("list length moved by more than one");

    a_wm_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> wm_reg >= $past(wm_reg))
        else $error("fill mark went backwards");

    a_count_le_wm: assert property (@(posedge clk) disable iff (!rst_n)
        LINK_W'(count_reg) <= wm_reg)
        else $error("more list nodes than nodes ever allocated");

    a_free_null_full: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg >= LINK_W'(CAPACITY) |-> count_reg == LEN_W'(CAPACITY))
        else $error("free list empty while pool not full");
`endif

endmodule

`default_nettype wire

### dv/indexed_linked_list_engine_tb.sv
// self-checking testbench for the indexed linked list engine: directed and random runs
`default_nettype none

module indexed_linked_list_engine_tb import ille_pkg::*;;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int ACT_MAX     = (1 << ACT_W) - 1;

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic [STAT_W-1:0]       status;
        logic [LEN_W-1:0]        length;
    } list_reply_t;

    class list_scoreboard;
        logic signed [VAL_W-1:0] contents[$];
        list_reply_t             awaiting[$];
        int unsigned             mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned length_now();
            return contents.size();
        endfunction

        function int unsigned replies_due();
            return awaiting.size();
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            list_reply_t reply;
            int unsigned n;
            int unsigned slot;
            bit          inserting;
            n = contents.size();
            reply.read_value = -1;
            reply.status = ST_DONE;
            inserting = 1'b0;
            slot = 0;
            case (act)
                ACT_GET:
                    if (pos >= n)
                        reply.status = ST_RANGE;
                    else
                        reply.read_value = contents[pos];
                ACT_ADD_HEAD:
                begin
                    inserting = 1'b1;
                    slot = 0;
                end
                ACT_ADD_TAIL:
                begin
                    inserting = 1'b1;
                    slot = n;
                end
                ACT_ADD_INDEX:
                begin
                    inserting = 1'b1;
                    slot = pos;
                end
                ACT_DELETE:
                    if (pos >= n)
                        reply.status = ST_RANGE;
                    else
                        contents.delete(pos);
                default:
                    ;
            endcase
            if (inserting)
            begin
                if (slot > n)
                    reply.status = ST_RANGE;
                else if (n >= CAPACITY)
                    reply.status = ST_FULL;
                else
                    contents.insert(slot, val);
            end
            reply.length = LEN_W'(contents.size());
            awaiting.push_back(reply);
        endfunction

        function void check_reply(logic signed [VAL_W-1:0] rv, logic [STAT_W-1:0] st,
                                  logic [LEN_W-1:0] len);
            list_reply_t want;
            if (awaiting.size() == 0)
            begin
                $display("%0t: unexpected response read_value %0d status %0d length %0d",
                         $time, rv, st, len);
                mismatches++;
                return;
            end
            want = awaiting.pop_front();
            if (rv !== want.read_value)
            begin
                $display("%0t: read_value expected %0d actual %0d", $time, want.read_value, rv);
                mismatches++;
            end
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                mismatches++;
            end
            if (len !== want.length)
            begin
                $display("%0t: length expected %0d actual %0d", $time, want.length, len);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ille_req_if req_ch ();
    ille_rsp_if rsp_ch ();

    indexed_linked_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard model;
    int unsigned    burst_left;
    int unsigned    stall_mode;
    int unsigned    stall_left;
    int unsigned    cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            model.check_reply(rsp_ch.read_value, rsp_ch.status, rsp_ch.length);
    end

    // receiver: phases of always ready, coin flips and long stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {1'b0, {(VAL_W-1){1'b1}}};
        else if (r == 1)
            return {1'b1, {(VAL_W-1){1'b0}}};
        return VAL_W'($urandom());
    endfunction

    task automatic issue_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val);
        int unsigned pause;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (pause)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.position   <= pos;
        req_ch.item_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        model.note_request(act, pos, val);
        burst_left--;
    endtask

    task automatic run_directed();
        issue_request(ACT_GET, POS_W'(0), pick_value());
        issue_request(ACT_DELETE, POS_W'(0), pick_value());
        issue_request(ACT_ADD_INDEX, POS_W'(1), pick_value());
        issue_request(ACT_ADD_INDEX, POS_W'(0), {1'b0, {(VAL_W-1){1'b1}}});
        issue_request(ACT_ADD_HEAD, POS_W'(0), {1'b1, {(VAL_W-1){1'b0}}});
        issue_request(ACT_ADD_TAIL, POS_W'(POS_MAX), -1);
        issue_request(ACT_ADD_INDEX, POS_W'(3), 0);
        issue_request(ACT_ADD_INDEX, POS_W'(1), 12345);
        for (int i = 0; i < 5; i++)
            issue_request(ACT_GET, POS_W'(i), pick_value());
        issue_request(ACT_GET, POS_W'(5), pick_value());
        issue_request(ACT_GET, POS_W'(POS_MAX), pick_value());
        issue_request(ACT_ADD_INDEX, POS_W'(POS_MAX), pick_value());
        issue_request(ACT_DELETE, POS_W'(5), pick_value());
        issue_request(ACT_DELETE, POS_W'(2), pick_value());
        issue_request(ACT_DELETE, POS_W'(0), pick_value());
        issue_request(ACT_DELETE, POS_W'(2), pick_value());
        for (int a = int'(ACT_DELETE) + 1; a <= ACT_MAX; a++)
            issue_request(ACT_W'(a), POS_W'($urandom_range(0, POS_MAX)), pick_value());
        issue_request(ACT_GET, POS_W'(0), pick_value());
        issue_request(ACT_GET, POS_W'(1), pick_value());
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned      n;
        int unsigned      pick;
        logic [POS_W-1:0] raw_pos;
        logic [POS_W-1:0] edge_pos;
        for (int unsigned i = 0; i < count; i++)
        begin
            n = model.length_now();
            pick = $urandom_range(0, 99);
            raw_pos = POS_W'($urandom_range(0, POS_MAX));
            edge_pos = ($urandom_range(0, 1) == 0) ? POS_W'(n) : POS_W'(n + 1);
            if (n >= 48 && pick >= 18 && pick < 52)
                pick = 60;
            if (pick < 18)
                issue_request(ACT_GET, (n > 0) ? POS_W'($urandom_range(0, n - 1)) : raw_pos,
                              pick_value());
            else if (pick < 28)
                issue_request(ACT_ADD_HEAD, raw_pos, pick_value());
            else if (pick < 38)
                issue_request(ACT_ADD_TAIL, raw_pos, pick_value());
            else if (pick < 52)
                issue_request(ACT_ADD_INDEX, POS_W'($urandom_range(0, n)), pick_value());
            else if (pick < 70)
                issue_request(ACT_DELETE, (n > 0) ? POS_W'($urandom_range(0, n - 1)) : raw_pos,
                              pick_value());
            else if (pick < 90)
                issue_request(ACT_W'($urandom_range(0, int'(ACT_DELETE))),
                              ($urandom_range(0, 1) == 0) ? edge_pos : raw_pos, pick_value());
            else
                issue_request(ACT_W'($urandom_range(int'(ACT_DELETE) + 1, ACT_MAX)), raw_pos,
                              pick_value());
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_GET;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        rsp_ch.ready      = 1'b0;
        burst_left        = 0;
        stall_mode        = 0;
        stall_left        = 0;
        cycle_count       = 0;
        model             = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random(555);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (model.replies_due() != 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);
        if (model.mismatches == 0 && model.replies_due() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
